[rtl/core/whtx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package whtx_pkg;

   // Default sizing of the vector stores.
   localparam int DEF_MAX_LENGTH    = 64;
   localparam int DEF_ELEMENT_WIDTH = 32;

   // Fixed widths of the channel fields and registers.
   localparam int OPERAND_WIDTH   = 32;
   localparam int INDEX_WIDTH     = 6;
   localparam int MODE_WIDTH      = 2;
   localparam int SIZE_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 3;

   // Width of one multiplier digit taken from the second factor per cycle.
   localparam int MUL_DIGIT = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIZE_LOG = 1'b1;

   // Mode codes; the unused code behaves as forward.
   localparam logic [MODE_WIDTH-1:0] MODE_FORWARD  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_INVERSE  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_CONVOLVE = 2'd2;

   // One input item.
   typedef struct packed {
      logic signed [OPERAND_WIDTH-1:0] first_operand;
      logic signed [OPERAND_WIDTH-1:0] second_operand;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [OPERAND_WIDTH-1:0] result_value;
      logic [INDEX_WIDTH-1:0]          result_index;
      logic                            final_flag;
   } rsp_type;

   // Controls from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic halve;
      logic mul_load;
      logic mul_step;
   } alu_ctl_type;

endpackage

`default_nettype wire

[rtl/core/whtx_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module whtx_ram import whtx_pkg::*; #(
   parameter int WIDTH = DEF_ELEMENT_WIDTH,
   parameter int DEPTH = DEF_MAX_LENGTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic      [WIDTH-1:0]         rd_data0,
   output logic      [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

`default_nettype wire

[rtl/core/whtx_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module whtx_alu import whtx_pkg::*; #(
   parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
   input  wire logic                     clock,
   input  wire alu_ctl_type              ctl,
   input  wire logic [ELEMENT_WIDTH-1:0] bf_x,
   input  wire logic [ELEMENT_WIDTH-1:0] bf_y,
   input  wire logic [ELEMENT_WIDTH-1:0] mul_a,
   input  wire logic [ELEMENT_WIDTH-1:0] mul_b,
   output logic      [ELEMENT_WIDTH-1:0] sum,
   output logic      [ELEMENT_WIDTH-1:0] diff,
   output logic      [ELEMENT_WIDTH-1:0] product
);

   localparam int EW = ELEMENT_WIDTH;
   localparam int DW = (EW < MUL_DIGIT) ? EW : MUL_DIGIT;

   logic [EW-1:0]    raw_sum;
   logic [EW-1:0]    raw_diff;
   logic [EW-1:0]    a_sh_ff, a_sh_in;
   logic [EW-1:0]    b_sh_ff, b_sh_in;
   logic [EW-1:0]    acc_ff, acc_in;
   logic [EW+DW-1:0] partial;

   // Signed halving that truncates toward zero: add one to negatives, then shift.
   function automatic logic [EW-1:0] half_trunc(input logic [EW-1:0] v);
      logic [EW:0] w;
      w = {v[EW-1], v} + {{EW{1'b0}}, v[EW-1]};
      return w[EW:1];
   endfunction

   // Butterfly: wrapping sum and difference, halved for the inverse pass.
   assign raw_sum  = bf_x + bf_y;
   assign raw_diff = bf_x - bf_y;
   assign sum      = ctl.halve ? half_trunc(raw_sum) : raw_sum;
   assign diff     = ctl.halve ? half_trunc(raw_diff) : raw_diff;

   // Multiplier: one digit of the second factor per cycle, low bits kept.
   assign partial = a_sh_ff * b_sh_ff[DW-1:0];

   always_comb begin
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      if (ctl.mul_load) begin
         a_sh_in = mul_a;
         b_sh_in = mul_b;
         acc_in  = '0;
      end else if (ctl.mul_step) begin
         a_sh_in = a_sh_ff << DW;
         b_sh_in = b_sh_ff >> DW;
         acc_in  = acc_ff + partial[EW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
   end

   assign product = acc_ff;

endmodule

`default_nettype wire

[rtl/core/walsh_hadamard_xor_convolution.sv]
`timescale 1ns / 1ps
`default_nettype none

// Walsh-Hadamard transform and XOR convolution engine.
// Items enter on the req_ channel, one element pair per item, one item per cycle while
// loading. After n = 2^size_log items (size_log capped at log2(MAX_LENGTH)) the block
// transforms the stored vector in place and sends n items on the rsp_ channel in index
// order, final_flag set on the last one. The user must write registers mode and size_log
// through the csr_ port only while no job is running; the block does not enforce this.
// Each butterfly pass runs on the shared add/subtract unit and one RAM read port pair;
// a butterfly writes its sum and then its difference through the one write port.
// Forward and inverse jobs run log2(n) passes; convolution transforms both vectors,
// multiplies them element by element in the digit-serial multiplier and runs the
// inverse transform on the product. Results then leave at one per cycle while
// rsp_ready is high. A stalled receiver holds the emit sequence; the last result sits
// in the output register while the next vector already loads. Reset clears the load
// count, returns to loading, drops rsp_valid and sets mode forward with size_log 6.
// Vector contents are not cleared: each job writes every entry it reads.
module walsh_hadamard_xor_convolution import whtx_pkg::*; #(
   parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
   parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int EW      = ELEMENT_WIDTH;
   localparam int AW      = $clog2(MAX_LENGTH);
   localparam int CW      = $clog2(MAX_LENGTH + 1);
   localparam int LOG_MAX = CW - 1;
   localparam int DW      = (EW < MUL_DIGIT) ? EW : MUL_DIGIT;
   localparam int NCHUNK  = (EW + DW - 1) / DW;
   localparam int CHW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   typedef enum logic [9:0] {
      ST_LOAD    = 10'b0000000001,
      ST_BF_RD   = 10'b0000000010,
      ST_BF_WR0  = 10'b0000000100,
      ST_BF_WR1  = 10'b0000001000,
      ST_MUL_RD  = 10'b0000010000,
      ST_MUL_LD  = 10'b0000100000,
      ST_MUL_RUN = 10'b0001000000,
      ST_MUL_WR  = 10'b0010000000,
      ST_EMIT_RD = 10'b0100000000,
      ST_EMIT    = 10'b1000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_FWD_A = 3'b001,
      PH_FWD_B = 3'b010,
      PH_INV_A = 3'b100
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [SIZE_WIDTH-1:0] size_log_ff, size_log_in;
   logic [SIZE_WIDTH-1:0] pass_ff, pass_in;
   logic [AW-1:0]         k_ff, k_in;
   logic [CHW-1:0]        chunk_ff, chunk_in;
   logic [CW-1:0]         load_count_ff, load_count_in;
   logic [EW-1:0]         diff_ff, diff_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_data_ff, out_data_in;

   logic [SIZE_WIDTH-1:0] lg_eff;
   logic [SIZE_WIDTH-1:0] stage;
   logic [CW-1:0]         n_val;
   logic [CW-1:0]         half_n;
   logic [CW-1:0]         load_next;
   logic [AW-1:0]         stride;
   logic [AW-1:0]         rd_k;
   logic                  bf_last;
   logic                  el_last;
   logic                  passes_done;
   logic                  sel_b;
   logic                  inverse;

   logic                  a_we, b_we;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr0, rd_addr1;
   logic [EW-1:0]         a_wr_data, b_wr_data;
   logic [EW-1:0]         a_rd0, a_rd1, b_rd0, b_rd1;
   logic [EW-1:0]         alu_sum, alu_diff, alu_product;
   alu_ctl_type           alu_ctl;

   // Lower element of butterfly kk: a zero bit inserted at the stride position.
   function automatic logic [AW-1:0] pair_lo(input logic [AW-1:0] kk,
                                              input logic [AW-1:0] s);
      logic [AW-1:0] mask;
      mask = s - AW'(1);
      return ((kk & ~mask) << 1) | (kk & mask);
   endfunction

   // Configuration registers.
   always_comb begin
      mode_in     = mode_ff;
      size_log_in = size_log_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:     mode_in     = csr_wr_data[MODE_WIDTH-1:0];
            CSR_SIZE_LOG: size_log_in = csr_wr_data[SIZE_WIDTH-1:0];
            default:      mode_in     = mode_ff;
         endcase
      end
   end

   // Job geometry: length clamped to the store, stride of the current pass.
   assign lg_eff      = (size_log_ff > SIZE_WIDTH'(LOG_MAX)) ? SIZE_WIDTH'(LOG_MAX)
                                                             : size_log_ff;
   assign n_val       = CW'(1) << lg_eff;
   assign half_n      = n_val >> 1;
   assign load_next   = load_count_ff + CW'(1);
   assign sel_b       = (phase_ff == PH_FWD_B);
   assign inverse     = (phase_ff == PH_INV_A);
   assign stage       = inverse ? (lg_eff - SIZE_WIDTH'(1) - pass_ff) : pass_ff;
   assign stride      = AW'(1) << stage;
   assign passes_done = (pass_ff == lg_eff);
   assign bf_last     = (CW'(k_ff) == half_n - CW'(1));
   assign el_last     = (CW'(k_ff) == n_val - CW'(1));

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      pass_in       = pass_ff;
      k_in          = k_ff;
      chunk_in      = chunk_ff;
      load_count_in = load_count_ff;
      diff_in       = diff_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_data_in   = out_data_ff;
      alu_ctl       = '0;
      alu_ctl.halve = inverse;
      a_we          = 1'b0;
      b_we          = 1'b0;
      wr_addr       = k_ff;
      a_wr_data     = alu_sum;
      b_wr_data     = alu_sum;
      rd_k          = k_ff;
      unique case (state_ff)
         ST_LOAD: begin
            // Store the pair; the last pair of the vector starts the job.
            if (req_valid) begin
               a_we      = 1'b1;
               b_we      = 1'b1;
               wr_addr   = load_count_ff[AW-1:0];
               a_wr_data = EW'(req_data.first_operand);
               b_wr_data = EW'(req_data.second_operand);
               if (load_next >= n_val) begin
                  load_count_in = '0;
                  pass_in       = '0;
                  k_in          = '0;
                  phase_in      = (mode_ff == MODE_INVERSE) ? PH_INV_A : PH_FWD_A;
                  state_in      = ST_BF_RD;
               end else begin
                  load_count_in = load_next;
               end
            end
         end
         ST_BF_RD: begin
            // Start of a pass, or end of the transform phase.
            if (passes_done) begin
               pass_in = '0;
               k_in    = '0;
               priority if (phase_ff == PH_FWD_A && mode_ff == MODE_CONVOLVE) begin
                  phase_in = PH_FWD_B;
               end else if (phase_ff == PH_FWD_B) begin
                  state_in = ST_MUL_RD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end else begin
               state_in = ST_BF_WR0;
            end
         end
         ST_BF_WR0: begin
            wr_addr = pair_lo(k_ff, stride);
            a_we    = ~sel_b;
            b_we    = sel_b;
            diff_in = alu_diff;
            state_in = ST_BF_WR1;
         end
         ST_BF_WR1: begin
            // Write the difference; fetch the next pair of the same pass unless this was the last.
            wr_addr   = pair_lo(k_ff, stride) | stride;
            a_we      = ~sel_b;
            b_we      = sel_b;
            a_wr_data = diff_ff;
            b_wr_data = diff_ff;
            if (bf_last) begin
               k_in     = '0;
               pass_in  = pass_ff + SIZE_WIDTH'(1);
               state_in = ST_BF_RD;
            end else begin
               k_in     = k_ff + AW'(1);
               rd_k     = k_ff + AW'(1);
               state_in = ST_BF_WR0;
            end
         end
         ST_MUL_RD: begin
            state_in = ST_MUL_LD;
         end
         ST_MUL_LD: begin
            alu_ctl.mul_load = 1'b1;
            chunk_in         = '0;
            state_in         = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            alu_ctl.mul_step = 1'b1;
            if (chunk_ff == CHW'(NCHUNK - 1)) begin
               state_in = ST_MUL_WR;
            end else begin
               chunk_in = chunk_ff + CHW'(1);
            end
         end
         ST_MUL_WR: begin
            // Store the product; fetch the next element pair unless this was the last.
            a_we      = 1'b1;
            a_wr_data = alu_product;
            if (el_last) begin
               k_in     = '0;
               pass_in  = '0;
               phase_in = PH_INV_A;
               state_in = ST_BF_RD;
            end else begin
               k_in     = k_ff + AW'(1);
               rd_k     = k_ff + AW'(1);
               state_in = ST_MUL_LD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Move one element into the output register whenever it frees up.
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in             = 1'b1;
               out_data_in.result_value = OPERAND_WIDTH'(a_rd0);
               out_data_in.result_index = INDEX_WIDTH'(k_ff);
               out_data_in.final_flag   = el_last;
               if (el_last) begin
                  k_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in = k_ff + AW'(1);
                  rd_k = k_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Read addresses: butterfly pairs in the pass states, plain index otherwise.
   assign rd_addr1 = pair_lo(rd_k, stride) | stride;
   assign rd_addr0 = (state_ff == ST_BF_RD || state_ff == ST_BF_WR1) ? pair_lo(rd_k, stride)
                                                                       : rd_k;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         phase_ff      <= PH_FWD_A;
         mode_ff       <= MODE_FORWARD;
         size_log_ff   <= SIZE_WIDTH'(6);
         pass_ff       <= '0;
         k_ff          <= '0;
         chunk_ff      <= '0;
         load_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         size_log_ff   <= size_log_in;
         pass_ff       <= pass_in;
         k_ff          <= k_in;
         chunk_ff      <= chunk_in;
         load_count_ff <= load_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      out_data_ff <= out_data_in;
   end

   // Vector stores.
   whtx_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LENGTH)
   ) u_store_a (
      .clock    (clock),
      .wr_en    (a_we),
      .wr_addr  (wr_addr),
      .wr_data  (a_wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   whtx_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LENGTH)
   ) u_store_b (
      .clock    (clock),
      .wr_en    (b_we),
      .wr_addr  (wr_addr),
      .wr_data  (b_wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   // Shared butterfly and multiply unit.
   whtx_alu #(
      .ELEMENT_WIDTH (EW)
   ) u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .bf_x    (sel_b ? b_rd0 : a_rd0),
      .bf_y    (sel_b ? b_rd1 : a_rd1),
      .mul_a   (a_rd0),
      .mul_b   (b_rd0),
      .sum     (alu_sum),
      .diff    (alu_diff),
      .product (alu_product)
   );

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
